### rtl/core/hsps_pkg.sv
package hsps_pkg;

  typedef enum logic [5:0] {
    ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_SPSID, ST_CHROMA, ST_SEPCOL, ST_DEPTHL, ST_DEPTHC,
    ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DELTA, ST_FRAMENUM, ST_POCTYPE, ST_POCLSB,
    ST_DELTAZERO, ST_OFFNONREF, ST_OFFTOP, ST_CYCLE, ST_OFFFRAME, ST_REFFRAMES, ST_GAPS,
    ST_WIDTH, ST_HEIGHT, ST_FRAMEMBS, ST_MBAFF, ST_DIRECT, ST_CROPFLAG, ST_CROPL, ST_CROPR,
    ST_CROPT, ST_CROPB
  } step_t;

  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_TRUNC = 2'd1;
  localparam logic [1:0] RES_RANGE = 2'd2;

  // fixed field width, 0 for Exp-Golomb
  function automatic logic [3:0] step_bits(input step_t s);
    case (s)
      ST_PROFILE, ST_CONSTR, ST_LEVEL: step_bits = 4'd8;
      ST_SEPCOL, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DELTAZERO, ST_GAPS,
      ST_FRAMEMBS, ST_MBAFF, ST_DIRECT, ST_CROPFLAG: step_bits = 4'd1;
      default: step_bits = 4'd0;
    endcase
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch a new byte into the shifter
    logic shift;  // feed one bit
    logic rearm;  // return to reset state
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       drop;   // latched byte is an emulation-prevention byte
    logic       done;   // bit just fed ended the parse
    logic [1:0] res;
  } dp_sts_t;

endpackage

### rtl/core/h264_sps_header_parser_core.sv
// channel | ports        | payload
// in      | in_t*        | tdata[7:0] data_byte, tlast is_last
// out     | out_t*       | tdata[55:0] status..interlaced
// Steps: a byte is loaded, checked, fed to the syntax decoder one bit per cycle
//   (up to 8, while the output is free) and ended; a dropped byte skips the bits,
//   and a byte that arrives after the result (ignored) goes straight to the end.
// Reset: rst_n synchronous, active low; parser re-arms after every last byte.
// Stalls: bit feeding and the end of a byte wait while the output register
//   holds an untaken beat.
module h264_sps_header_parser_core #(
  parameter int MAX_LEADING_ZEROS = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0] profile[9:2] level[17:10] ref_frames[25:18] width_mbs[36:26]
  // height_mbs[48:37] interlaced[49], zeros above
  output logic [55:0] out_tdata
);
  import hsps_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [2:0]  bit_idx;
  logic        emit, emit_trunc, out_free;
  logic [1:0]  o_status;
  logic [7:0]  o_profile, o_level, o_ref;
  logic [10:0] o_width;
  logic [11:0] o_height;
  logic        o_inter;
  logic        ov_r, ov_nxt;
  logic [55:0] od_r, od_nxt;

  assign out_free = !ov_r || out_tready;

  hsps_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(in_tvalid && in_tready), .in_last(in_tlast), .out_free,
    .sts, .in_ready(in_tready), .cmd, .bit_idx, .emit, .emit_trunc
  );

  hsps_datapath #(.MAX_LEADING_ZEROS(MAX_LEADING_ZEROS)) u_dp (
    .clk, .rst_n, .byte_in(in_tdata), .cmd, .bit_idx, .sts, .o_status, .o_profile,
    .o_level, .o_ref, .o_width, .o_height, .o_inter
  );

  always_comb begin
    ov_nxt = ov_r && !out_tready;
    od_nxt = od_r;
    if (emit) begin
      ov_nxt = 1'b1;
      if (emit_trunc) od_nxt = {54'd0, RES_TRUNC};
      else if (o_status != RES_OK) od_nxt = {54'd0, o_status};
      else od_nxt = {6'd0, o_inter, o_height, o_width, o_ref, o_level, o_profile, o_status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= ov_nxt;
  end
  always_ff @(posedge clk) od_r <= od_nxt;

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule

### rtl/core/hsps_datapath.sv
module hsps_datapath #(
  parameter int MAX_LEADING_ZEROS = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        byte_in,
  input  hsps_pkg::dp_cmd_t cmd,
  input  logic [2:0]        bit_idx,
  output hsps_pkg::dp_sts_t sts,
  output logic [1:0]        o_status,
  output logic [7:0]        o_profile,
  output logic [7:0]        o_level,
  output logic [7:0]        o_ref,
  output logic [10:0]       o_width,
  output logic [11:0]       o_height,
  output logic              o_inter
);
  import hsps_pkg::*;

  logic [15:0] prev_r, prev_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        drop_r, drop_nxt;
  step_t       step_r, step_nxt;
  logic [5:0]  zc_r, zc_nxt;
  logic [5:0]  bl_r, bl_nxt;
  logic [31:0] fv_r, fv_nxt;
  logic [2:0]  li_r, li_nxt;
  logic [6:0]  ci_r, ci_nxt;
  logic [7:0]  ls_r, ls_nxt, ns_r, ns_nxt;
  logic [7:0]  cc_r, cc_nxt;
  logic [7:0]  prof_r, prof_nxt, lev_r, lev_nxt, ref_r, ref_nxt;
  logic [9:0]  w_r, w_nxt, h_r, h_nxt;
  logic        il_r, il_nxt;

  logic        b, comp;
  logic [32:0] v;
  logic [31:0] egbase, h, d;
  logic [7:0]  nsv;
  logic [6:0]  sz;
  logic [3:0]  fb;
  logic [1:0]  res;
  logic        dn;

  always_comb begin
    prev_nxt = prev_r; byte_nxt = byte_r; drop_nxt = drop_r;
    step_nxt = step_r; zc_nxt = zc_r; bl_nxt = bl_r; fv_nxt = fv_r;
    li_nxt = li_r; ci_nxt = ci_r; ls_nxt = ls_r; ns_nxt = ns_r; cc_nxt = cc_r;
    prof_nxt = prof_r; lev_nxt = lev_r; ref_nxt = ref_r; w_nxt = w_r; h_nxt = h_r;
    il_nxt = il_r;
    dn = 1'b0; res = RES_OK; comp = 1'b0; v = '0;
    b = byte_r[bit_idx];
    fb = step_bits(step_r);
    egbase = (32'd1 << zc_r[4:0]) - 32'd1;
    h = '0; d = '0; nsv = '0; sz = '0;
    if (cmd.load) begin
      drop_nxt = (prev_r == 16'h0000) && (byte_in == 8'h03);
      prev_nxt = {prev_r[7:0], byte_in};
      byte_nxt = byte_in;
    end
    if (cmd.shift) begin
      if (fb != 4'd0) begin
        fv_nxt = {fv_r[30:0], b};
        bl_nxt = bl_r - 6'd1;
        if (bl_r == 6'd1) begin comp = 1'b1; v = {1'b0, fv_nxt}; end
      end else if (bl_r == 6'd0) begin
        if (!b) begin
          zc_nxt = zc_r + 6'd1;
          if (zc_nxt > 6'(MAX_LEADING_ZEROS)) begin dn = 1'b1; res = RES_RANGE; end
        end else if (zc_r == 6'd0) begin
          comp = 1'b1;
        end else begin
          bl_nxt = zc_r; fv_nxt = '0;
        end
      end else begin
        fv_nxt = {fv_r[30:0], b};
        bl_nxt = bl_r - 6'd1;
        if (bl_r == 6'd1) begin comp = 1'b1; v = {1'b0, egbase} + {1'b0, fv_nxt}; end
      end
      if (comp) begin
        step_nxt = step_r;
        case (step_r)
          ST_PROFILE: begin prof_nxt = v[7:0]; step_nxt = ST_CONSTR; end
          ST_CONSTR:  step_nxt = ST_LEVEL;
          ST_LEVEL:   begin lev_nxt = v[7:0]; step_nxt = ST_SPSID; end
          ST_SPSID:   step_nxt = (prof_r == 8'd100) ? ST_CHROMA : ST_FRAMENUM;
          ST_CHROMA: begin
            if (v > 33'd3) begin dn = 1'b1; res = RES_RANGE; end
            step_nxt = (v == 33'd3) ? ST_SEPCOL : ST_DEPTHL;
          end
          ST_SEPCOL: step_nxt = ST_DEPTHL;
          ST_DEPTHL: step_nxt = ST_DEPTHC;
          ST_DEPTHC: step_nxt = ST_BYPASS;
          ST_BYPASS: step_nxt = ST_MATRIX;
          ST_MATRIX: begin
            li_nxt = '0;
            step_nxt = v[0] ? ST_LISTFLAG : ST_FRAMENUM;
          end
          ST_LISTFLAG, ST_DELTA: begin
            if (step_r == ST_LISTFLAG) begin
              ls_nxt = 8'd8; ns_nxt = 8'd8; ci_nxt = '0;
            end else begin
              h = v[32:1];
              d = v[0] ? h + 32'd1 : 32'd0 - h;
              nsv = ls_r + d[7:0];
              ns_nxt = nsv;
              if (nsv != 8'd0) ls_nxt = nsv;
              ci_nxt = ci_r + 7'd1;
            end
            sz = (li_r < 3'd6) ? 7'd16 : 7'd64;
            if ((step_r == ST_DELTA || v[0]) && ns_nxt != 8'd0 && ci_nxt < sz)
              step_nxt = ST_DELTA;
            else if (li_r == 3'd7) step_nxt = ST_FRAMENUM;
            else begin li_nxt = li_r + 3'd1; step_nxt = ST_LISTFLAG; end
          end
          ST_FRAMENUM: step_nxt = ST_POCTYPE;
          ST_POCTYPE: begin
            if (v > 33'd2) begin dn = 1'b1; res = RES_RANGE; end
            step_nxt = (v == 33'd0) ? ST_POCLSB : (v == 33'd1) ? ST_DELTAZERO : ST_REFFRAMES;
          end
          ST_POCLSB:    step_nxt = ST_REFFRAMES;
          ST_DELTAZERO: step_nxt = ST_OFFNONREF;
          ST_OFFNONREF: step_nxt = ST_OFFTOP;
          ST_OFFTOP:    step_nxt = ST_CYCLE;
          ST_CYCLE: begin
            if (v > 33'd255) begin dn = 1'b1; res = RES_RANGE; end
            cc_nxt = v[7:0];
            step_nxt = (v[7:0] == 8'd0) ? ST_REFFRAMES : ST_OFFFRAME;
          end
          ST_OFFFRAME: begin
            if (cc_r != 8'd0) cc_nxt = cc_r - 8'd1;
            step_nxt = (cc_nxt == 8'd0) ? ST_REFFRAMES : ST_OFFFRAME;
          end
          ST_REFFRAMES: begin
            if (v > 33'd255) begin dn = 1'b1; res = RES_RANGE; end
            ref_nxt = v[7:0]; step_nxt = ST_GAPS;
          end
          ST_GAPS: step_nxt = ST_WIDTH;
          ST_WIDTH: begin
            if (v > 33'd1023) begin dn = 1'b1; res = RES_RANGE; end
            w_nxt = v[9:0]; step_nxt = ST_HEIGHT;
          end
          ST_HEIGHT: begin
            if (v > 33'd1023) begin dn = 1'b1; res = RES_RANGE; end
            h_nxt = v[9:0]; step_nxt = ST_FRAMEMBS;
          end
          ST_FRAMEMBS: begin
            il_nxt = !v[0];
            step_nxt = v[0] ? ST_DIRECT : ST_MBAFF;
          end
          ST_MBAFF:  step_nxt = ST_DIRECT;
          ST_DIRECT: step_nxt = ST_CROPFLAG;
          ST_CROPFLAG: begin
            if (!v[0]) dn = 1'b1;
            step_nxt = ST_CROPL;
          end
          ST_CROPL: step_nxt = ST_CROPR;
          ST_CROPR: step_nxt = ST_CROPT;
          ST_CROPT: step_nxt = ST_CROPB;
          default: dn = 1'b1;
        endcase
        // start() of the next field
        bl_nxt = {2'b0, step_bits(step_nxt)};
        zc_nxt = '0;
        fv_nxt = '0;
      end
    end
    if (cmd.rearm) begin
      prev_nxt = 16'hFFFF; step_nxt = ST_PROFILE; zc_nxt = '0; bl_nxt = 6'd8;
      fv_nxt = '0; li_nxt = '0; ci_nxt = '0; ls_nxt = 8'd8; ns_nxt = 8'd8; cc_nxt = '0;
      prof_nxt = '0; lev_nxt = '0; ref_nxt = '0; w_nxt = '0; h_nxt = '0; il_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 16'hFFFF; step_r <= ST_PROFILE; zc_r <= '0; bl_r <= 6'd8; fv_r <= '0;
      li_r <= '0; ci_r <= '0; ls_r <= 8'd8; ns_r <= 8'd8; cc_r <= '0;
      prof_r <= '0; lev_r <= '0; ref_r <= '0; w_r <= '0; h_r <= '0; il_r <= 1'b0;
      drop_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt; step_r <= step_nxt; zc_r <= zc_nxt; bl_r <= bl_nxt;
      fv_r <= fv_nxt; li_r <= li_nxt; ci_r <= ci_nxt; ls_r <= ls_nxt; ns_r <= ns_nxt;
      cc_r <= cc_nxt; prof_r <= prof_nxt; lev_r <= lev_nxt; ref_r <= ref_nxt;
      w_r <= w_nxt; h_r <= h_nxt; il_r <= il_nxt; drop_r <= drop_nxt;
    end
  end

  always_ff @(posedge clk) byte_r <= byte_nxt;

  assign sts.drop = drop_r;
  assign sts.done = dn;
  assign sts.res  = res;

  // result fields from current state (valid when the parse completes)
  logic [11:0] hsum;
  assign hsum      = {2'b0, h_r} + 12'd1;
  assign o_status  = res;
  assign o_profile = prof_r;
  assign o_level   = lev_r;
  assign o_ref     = ref_r;
  assign o_width   = {1'b0, w_r} + 11'd1;
  assign o_height  = il_r ? {hsum[10:0], 1'b0} : hsum;
  assign o_inter   = il_r;
endmodule

### rtl/core/hsps_ctrl.sv
module hsps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_last,
  input  logic              out_free,
  input  hsps_pkg::dp_sts_t sts,
  output logic              in_ready,
  output hsps_pkg::dp_cmd_t cmd,
  output logic [2:0]        bit_idx,
  output logic              emit,
  output logic              emit_trunc
);
  import hsps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_CHECK = 4'b0010, S_BITS = 4'b0100, S_END = 4'b1000
  } state_t;

  state_t     st_r, st_nxt;
  logic [2:0] bi_r, bi_nxt;
  logic       last_r, last_nxt;
  logic       fin_r, fin_nxt;

  always_comb begin
    st_nxt = st_r; bi_nxt = bi_r; last_nxt = last_r; fin_nxt = fin_r;
    cmd = '0; emit = 1'b0; emit_trunc = 1'b0;
    in_ready = (st_r == S_IDLE);
    case (st_r)
      S_IDLE: if (in_fire) begin
        last_nxt = in_last; bi_nxt = 3'd7;
        if (fin_r) st_nxt = S_END;
        else begin cmd.load = 1'b1; st_nxt = S_CHECK; end
      end
      S_CHECK: st_nxt = sts.drop ? S_END : S_BITS;
      S_BITS: if (out_free) begin
        cmd.shift = 1'b1;
        if (sts.done) begin
          emit = 1'b1; fin_nxt = 1'b1; st_nxt = S_END;
        end else if (bi_r == 3'd0) st_nxt = S_END;
        else bi_nxt = bi_r - 3'd1;
      end
      S_END: if (out_free) begin
        if (last_r) begin
          if (!fin_r) begin emit = 1'b1; emit_trunc = 1'b1; end
          cmd.rearm = 1'b1; fin_nxt = 1'b0;
        end
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; bi_r <= '0; last_r <= 1'b0; fin_r <= 1'b0;
    end else begin
      st_r <= st_nxt; bi_r <= bi_nxt; last_r <= last_nxt; fin_r <= fin_nxt;
    end
  end

  assign bit_idx = bi_r;
endmodule

### bench/sps_result_checker.sv
module sps_result_checker
  import hsps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LZ_MAX = 31;
  localparam int STILL_PARSING = -1;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  profile;
    logic [7:0]  level;
    logic [7:0]  ref_frames;
    logic [10:0] width_mbs;
    logic [11:0] height_mbs;
    logic        interlaced;
  } sps_info_t;

  sps_info_t   info_q[$];

  logic [15:0] last_two;
  step_t       step;
  int unsigned zeros, remaining;
  logic [31:0] acc;
  int unsigned list_no, coeff_no;
  logic [7:0]  last_sc, next_sc;
  int unsigned poc_cycle;
  logic [7:0]  prof, lvl, refs;
  logic [9:0]  w_m1, h_m1;
  logic        field_coded;
  logic        done;

  function automatic int unsigned field_width(step_t s);
    case (s)
      ST_PROFILE, ST_CONSTR, ST_LEVEL: return 8;
      ST_SEPCOL, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DELTAZERO, ST_GAPS,
      ST_FRAMEMBS, ST_MBAFF, ST_DIRECT, ST_CROPFLAG: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic go(step_t s);
    step = s;
    remaining = field_width(s);
    zeros = 0;
    acc = '0;
  endtask

  task automatic rearm();
    last_two = 16'hFFFF;
    list_no = 0;
    coeff_no = 0;
    last_sc = 8'd8;
    next_sc = 8'd8;
    poc_cycle = 0;
    prof = '0; lvl = '0; refs = '0; w_m1 = '0; h_m1 = '0; field_coded = 1'b0;
    done = 1'b0;
    go(ST_PROFILE);
  endtask

  task automatic close_list();
    if (list_no >= 7) go(ST_FRAMENUM);
    else begin
      list_no++;
      go(ST_LISTFLAG);
    end
  endtask

  task automatic next_coeff();
    if (next_sc != 0 && coeff_no < ((list_no < 6) ? 16 : 64)) go(ST_DELTA);
    else close_list();
  endtask

  // a finished syntax element moves the parse along; returns status or still parsing
  task automatic finish_field(input longint unsigned v, output int r);
    logic [31:0] delta;
    r = STILL_PARSING;
    case (step)
      ST_PROFILE: begin prof = v[7:0]; go(ST_CONSTR); end
      ST_CONSTR: go(ST_LEVEL);
      ST_LEVEL: begin lvl = v[7:0]; go(ST_SPSID); end
      ST_SPSID: go(prof == 8'd100 ? ST_CHROMA : ST_FRAMENUM);
      ST_CHROMA: begin
        if (v > 3) r = RES_RANGE;
        else go(v == 3 ? ST_SEPCOL : ST_DEPTHL);
      end
      ST_SEPCOL: go(ST_DEPTHL);
      ST_DEPTHL: go(ST_DEPTHC);
      ST_DEPTHC: go(ST_BYPASS);
      ST_BYPASS: go(ST_MATRIX);
      ST_MATRIX: begin
        if (v != 0) begin list_no = 0; go(ST_LISTFLAG); end
        else go(ST_FRAMENUM);
      end
      ST_LISTFLAG: begin
        if (v != 0) begin
          last_sc = 8'd8; next_sc = 8'd8; coeff_no = 0;
          next_coeff();
        end else close_list();
      end
      ST_DELTA: begin
        // signed Exp-Golomb mapping, sum wraps at 8 bits
        delta = v[0] ? 32'(v >> 1) + 1 : 32'd0 - 32'(v >> 1);
        next_sc = last_sc + delta[7:0];
        if (next_sc != 0) last_sc = next_sc;
        coeff_no++;
        next_coeff();
      end
      ST_FRAMENUM: go(ST_POCTYPE);
      ST_POCTYPE: begin
        if (v > 2) r = RES_RANGE;
        else go(v == 0 ? ST_POCLSB : (v == 1 ? ST_DELTAZERO : ST_REFFRAMES));
      end
      ST_POCLSB: go(ST_REFFRAMES);
      ST_DELTAZERO: go(ST_OFFNONREF);
      ST_OFFNONREF: go(ST_OFFTOP);
      ST_OFFTOP: go(ST_CYCLE);
      ST_CYCLE: begin
        if (v > 255) r = RES_RANGE;
        else begin
          poc_cycle = 32'(v);
          go(poc_cycle == 0 ? ST_REFFRAMES : ST_OFFFRAME);
        end
      end
      ST_OFFFRAME: begin
        if (poc_cycle != 0) poc_cycle--;
        go(poc_cycle == 0 ? ST_REFFRAMES : ST_OFFFRAME);
      end
      ST_REFFRAMES: begin
        if (v > 255) r = RES_RANGE;
        else begin refs = v[7:0]; go(ST_GAPS); end
      end
      ST_GAPS: go(ST_WIDTH);
      ST_WIDTH: begin
        if (v > 1023) r = RES_RANGE;
        else begin w_m1 = v[9:0]; go(ST_HEIGHT); end
      end
      ST_HEIGHT: begin
        if (v > 1023) r = RES_RANGE;
        else begin h_m1 = v[9:0]; go(ST_FRAMEMBS); end
      end
      ST_FRAMEMBS: begin
        if (v == 0) begin field_coded = 1'b1; go(ST_MBAFF); end
        else go(ST_DIRECT);
      end
      ST_MBAFF: go(ST_DIRECT);
      ST_DIRECT: go(ST_CROPFLAG);
      ST_CROPFLAG: begin
        if (v == 0) r = RES_OK;
        else go(ST_CROPL);
      end
      ST_CROPL: go(ST_CROPR);
      ST_CROPR: go(ST_CROPT);
      ST_CROPT: go(ST_CROPB);
      default: r = RES_OK;
    endcase
  endtask

  task automatic take_bit(input logic b, output int r);
    r = STILL_PARSING;
    if (field_width(step) != 0) begin
      acc = {acc[30:0], b};
      remaining--;
      if (remaining == 0) finish_field(acc, r);
    end else if (remaining == 0) begin
      if (!b) begin
        zeros++;
        if (zeros > LZ_MAX) r = RES_RANGE;
      end else if (zeros == 0) finish_field(0, r);
      else begin
        remaining = zeros;
        acc = '0;
      end
    end else begin
      acc = {acc[30:0], b};
      remaining--;
      if (remaining == 0) finish_field(((64'd1 << zeros) - 1) + acc, r);
    end
  endtask

  function automatic sps_info_t make_info(int r);
    sps_info_t e;
    e = '0;
    e.status = r[1:0];
    if (r == RES_OK) begin
      e.profile = prof;
      e.level = lvl;
      e.ref_frames = refs;
      e.width_mbs = 11'(w_m1) + 11'd1;
      e.height_mbs = (12'(h_m1) + 12'd1) << field_coded;
      e.interlaced = field_coded;
    end
    return e;
  endfunction

  task automatic predict_beat(input logic [7:0] byte_in, input logic last);
    int r;
    logic ep;
    if (!done) begin
      ep = (last_two == 16'h0000) && (byte_in == 8'h03);
      last_two = {last_two[7:0], byte_in};
      if (!ep) begin
        for (int i = 7; i >= 0; i--) begin
          take_bit(byte_in[i], r);
          if (r != STILL_PARSING) begin
            info_q.push_back(make_info(r));
            done = 1'b1;
            break;
          end
        end
      end
    end
    if (last) begin
      if (!done) info_q.push_back(make_info(RES_TRUNC));
      rearm();
    end
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    fail_count = 0;
    rearm();
  end

  assign pending = info_q.size();

  always @(posedge clk) begin
    sps_info_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (info_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat, expected none, got %h", $time, out_tdata);
      end else begin
        e = info_q.pop_front();
        check_field("status", e.status, out_tdata[1:0]);
        check_field("profile", e.profile, out_tdata[9:2]);
        check_field("level", e.level, out_tdata[17:10]);
        check_field("ref_frames", e.ref_frames, out_tdata[25:18]);
        check_field("width_mbs", e.width_mbs, out_tdata[36:26]);
        check_field("height_mbs", e.height_mbs, out_tdata[48:37]);
        check_field("interlaced", e.interlaced, out_tdata[49]);
        check_field("padding", 0, out_tdata[55:50]);
      end
    end
    if (rst_n && in_tvalid && in_tready) predict_beat(in_tdata, in_tlast);
  end

endmodule

### bench/tb_h264_sps_header_parser_core.sv
module tb_h264_sps_header_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  // no-beat cycles tolerated
  localparam int STALL_LIMIT = 4000;
  localparam int TARGET_BEATS = 1200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte
  logic        in_tlast;   // is_last
  logic        out_tvalid;
  logic        out_tready;
  // status, profile, level, ref_frames, width_mbs, height_mbs, interlaced
  logic [55:0] out_tdata;

  int fail_count;
  int pending;
  bit calm;          // no idling on either side while set
  int stall_cycles;

  bit       nal_bits[$];   // RBSP bits of the payload being built
  bit [8:0] beat_q[$];     // {is_last, data_byte} ready to send

  h264_sps_header_parser_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  sps_result_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random backpressure, none during the calm stretch
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 34);
  end

  task automatic put_bits(longint unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) nal_bits.push_back(v[i]);
  endtask

  // Exp-Golomb code of v
  task automatic put_ue(longint unsigned v);
    longint unsigned x;
    int n;
    x = v + 1;
    n = 0;
    while ((x >> (n + 1)) != 0) n++;
    put_bits(0, n);
    put_bits(x, n + 1);
  endtask

  // mostly small values, sometimes the top of the legal range or just past it
  function automatic longint unsigned pick(longint unsigned top, int bad_pct);
    int r;
    r = $urandom_range(99);
    if (r < bad_pct) return top + 1 + $urandom_range(3);
    if (r < bad_pct + 10) return top;
    return $urandom_range(top < 20 ? top : 20);
  endfunction

  // turn nal_bits into bytes with emulation prevention, then queue as beats
  task automatic flush_payload(bit chop, int extra);
    bit [7:0] raw[$];
    bit [7:0] b;
    bit [7:0] coded[$];
    int zrun;
    int n;
    nal_bits.push_back(1'b1);  // stop bit, then align
    while (nal_bits.size() % 8 != 0) nal_bits.push_back(1'b0);
    while (nal_bits.size() != 0) begin
      for (int i = 0; i < 8; i++) b = {b[6:0], nal_bits.pop_front()};
      raw.push_back(b);
    end
    repeat (extra) raw.push_back($urandom_range(255));
    zrun = 0;
    foreach (raw[i]) begin
      if (zrun >= 2 && raw[i] <= 8'd3) begin
        coded.push_back(8'h03);
        zrun = 0;
      end
      coded.push_back(raw[i]);
      zrun = (raw[i] == 0) ? zrun + 1 : 0;
    end
    n = coded.size();
    if (chop) n = $urandom_range(1, n);
    for (int i = 0; i < n; i++) beat_q.push_back({i == n - 1, coded[i]});
  endtask

  task automatic build_sps(bit [7:0] profile, bit big, bit fields);
    longint unsigned v;
    int poc;
    put_bits(profile, 8);
    put_bits($urandom_range(255), 8);
    put_bits($urandom_range(255), 8);
    put_ue(pick(31, 0));
    if (profile == 8'd100) begin
      v = pick(3, 4);
      put_ue(v);
      if (v == 3) put_bits($urandom_range(1), 1);
      put_ue($urandom_range(6));
      put_ue($urandom_range(6));
      put_bits($urandom_range(1), 1);
      v = $urandom_range(1);
      put_bits(v, 1);
      if (v) begin
        for (int l = 0; l < 8; l++) begin
          v = $urandom_range(1);
          put_bits(v, 1);
          if (v) repeat (l < 6 ? 16 : 64) put_ue($urandom_range(3) == 0 ? $urandom_range(300)
                                                                        : $urandom_range(8));
        end
      end
    end
    put_ue($urandom_range(12));
    poc = int'(pick(2, 4));
    put_ue(poc);
    if (poc == 0) put_ue($urandom_range(12));
    else if (poc == 1) begin
      put_bits($urandom_range(1), 1);
      put_ue($urandom_range(40));
      put_ue($urandom_range(40));
      v = pick(255, 3);
      if (v > 8 && v <= 255 && !big) v = $urandom_range(8);
      put_ue(v);
      if (v <= 255) repeat (v) put_ue($urandom_range(40));
    end
    put_ue(big ? 255 : pick(255, 3));
    put_bits($urandom_range(1), 1);
    put_ue(big ? 1023 : pick(1023, 3));
    put_ue(big ? 1023 : pick(1023, 3));
    v = big ? 0 : $urandom_range(1);
    put_bits(v, 1);
    if (!v) put_bits($urandom_range(1), 1);
    put_bits($urandom_range(1), 1);
    put_bits(fields, 1);
    if (fields) repeat (4) put_ue($urandom_range(30));
  endtask

  // one random payload: mostly well-formed, some truncated, some noise
  task automatic random_payload();
    int kind;
    bit [7:0] prof;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) beat_q.push_back({1'b0, 8'($urandom_range(255))});
      beat_q.push_back({1'b1, 8'($urandom_range(255))});
    end else if (kind < 11) begin
      // oversize Exp-Golomb code in the id field
      put_bits(8'd66, 8); put_bits(0, 16); put_bits(0, 33);
      flush_payload(1'b0, 0);
    end else begin
      case ($urandom_range(3))
        0, 1: prof = 8'd100;
        2: prof = ($urandom_range(1) != 0) ? 8'd66 : 8'd77;
        default: prof = $urandom_range(255);
      endcase
      build_sps(prof, $urandom_range(15) == 0, $urandom_range(1));
      flush_payload(kind < 25, ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
    end
  endtask

  task automatic send_queued(ref int sent);
    bit [8:0] beat;
    while (beat_q.size() != 0) begin
      if (!calm && $urandom_range(99) < 34) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end else begin
        beat = beat_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= beat[7:0];
        in_tlast <= beat[8];
        while (!in_tready) @(negedge clk);  // ready is stable until the next rising edge
        @(negedge clk);                     // beat taken at the rising edge just passed
        sent++;
      end
    end
  endtask

  // watchdog on cycles where neither channel moves a beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** h264_sps_header_parser_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int sent;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    calm = 1'b0;
    sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: emulation byte plus oversize code, a lone last byte, largest legal
    // picture with field coding, then ue(1024) from the gaps flag on (in-range width)
    beat_q.push_back({1'b0, 8'h00}); beat_q.push_back({1'b0, 8'h00});
    beat_q.push_back({1'b0, 8'h03});
    repeat (5) beat_q.push_back({1'b0, 8'h00});
    beat_q.push_back({1'b1, 8'h00});
    beat_q.push_back({1'b1, 8'hFF});
    build_sps(8'd66, 1'b1, 1'b0);
    flush_payload(1'b0, 1);
    put_bits(8'd77, 8); put_bits(8'hFF, 8); put_bits(8'hFF, 8);
    put_ue(0); put_ue(0); put_ue(0); put_ue(0); put_bits(1, 1); put_ue(1024);
    flush_payload(1'b0, 0);
    send_queued(sent);

    while (sent < TARGET_BEATS) begin
      calm = (sent > TARGET_BEATS / 2) && (sent < TARGET_BEATS / 2 + 200);
      random_payload();
      send_queued(sent);
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("** h264_sps_header_parser_core: PASSED **");
    end else begin
      $display("** h264_sps_header_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
